// ===== design/rng_pkg.sv =====
// Shared types and constants for the relative neighborhood graph block.
`timescale 1ns / 1ps
`default_nettype none
package rng_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int INDEX_BITS  = 6;
   localparam int COUNT_BITS  = 7;
   localparam int COORD_BITS  = 16;
   localparam int CELL_BITS   = 8;
   localparam int WINDOW_BITS = 8;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int DIST_BITS   = 2 * DIFF_BITS;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_POINT_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CELL_WINDOW = 1'b1;

   // Item kinds.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                          kind;
      logic [INDEX_BITS-1:0]         index;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic [CELL_BITS-1:0]          grid_col;
      logic [CELL_BITS-1:0]          grid_row;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] row_point;
      logic [INDEX_BITS-1:0] neighbor;
      logic                  is_edge;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [CELL_BITS-1:0]         col;
      logic [CELL_BITS-1:0]         row;
   } point_type;

   localparam int POINT_BITS = $bits(point_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_I,
      ST_LD_I,
      ST_RD_J,
      ST_LD_J,
      ST_K_A,
      ST_K_B,
      ST_K_LAST,
      ST_DRAIN,
      ST_NEXT_J
   } state_type;

   // Which distance a pipeline slot carries.
   typedef enum logic [1:0] {
      SIDE_REF,
      SIDE_I,
      SIDE_J
   } side_type;

endpackage
`default_nettype wire

// ===== design/rng_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rng_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/relative_neighborhood_graph.sv =====
// Relative neighborhood graph row evaluator over a stored set of 2D points.
//
//   channel   | ports                                     | direction
//   ----------+-------------------------------------------+----------
//   request   | start, busy, req_data                     | in
//   response  | rsp_valid, rsp_data                       | out
//   registers | csr_valid, csr_ready, csr_index, csr_data | in
//
// A load writes the point store; a row past the count or with no earlier point answers next cycle.
// Other rows fetch point i, then each earlier j is skipped if its cells fail the window;
// else one squared distance is issued a cycle, two per third point, until a third point
// beats the pair or none is left, and then the distance pipeline drains.
// Reset is synchronous; busy is low and the point store keeps stale contents.
// Register writes wait while busy is high; results are one-cycle strobes and cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module relative_neighborhood_graph (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire rng_pkg::req_type                      req_data,
   output logic                                       rsp_valid,
   output rng_pkg::rsp_type                           rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [rng_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [rng_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   // Configuration registers.
   logic [rng_pkg::COUNT_BITS-1:0]  pc_ff;
   logic [rng_pkg::WINDOW_BITS-1:0] win_ff;

   // Sequencer state.
   rng_pkg::state_type              state_ff, state_in;
   logic [rng_pkg::INDEX_BITS-1:0]  i_ff, i_in;
   logic [rng_pkg::INDEX_BITS-1:0]  j_ff, j_in;
   logic [rng_pkg::INDEX_BITS-1:0]  k_ff, k_in;
   logic [rng_pkg::COUNT_BITS-1:0]  n_ff, n_in;
   rng_pkg::point_type              pi_ff, pi_in;
   rng_pkg::point_type              pj_ff, pj_in;
   logic                            jv_ff, jv_in;
   logic                            beaten_ff, beaten_in;
   logic                            pend_v_ff, pend_v_in;
   logic [rng_pkg::INDEX_BITS-1:0]  pend_j_ff, pend_j_in;
   logic [rng_pkg::DIST_BITS-1:0]   dij_ff, dij_in;
   logic [rng_pkg::DIST_BITS-1:0]   dik_ff, dik_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rng_pkg::rsp_type                rsp_ff, rsp_in;

   // Squared-distance pipeline.
   logic                                   v1_ff, v2_ff, v3_ff;
   rng_pkg::side_type                      s1_ff, s2_ff, s3_ff;
   logic signed [rng_pkg::DIFF_BITS-1:0]   dx1_ff, dy1_ff;
   logic signed [rng_pkg::DIST_BITS-1:0]   sqx2_ff, sqy2_ff;
   logic [rng_pkg::DIST_BITS-1:0]          d3_ff;

   // Issue and memory control.
   logic                                   iss_v;
   rng_pkg::side_type                      iss_side;
   logic                                   iss_a_j;
   rng_pkg::point_type                     op_a;
   rng_pkg::point_type                     rd_pt;
   logic [rng_pkg::POINT_BITS-1:0]         rd_word;
   logic                                   ram_we;
   logic [rng_pkg::INDEX_BITS-1:0]         ram_raddr;
   rng_pkg::point_type                     wr_pt;

   logic [rng_pkg::COUNT_BITS-1:0]         n_sat;
   logic [rng_pkg::COUNT_BITS-1:0]         n_m1;
   logic [rng_pkg::DIST_BITS-1:0]          dmax;
   logic [rng_pkg::CELL_BITS-1:0]          col_diff, row_diff;
   logic                                   win_ok;
   logic                                   k_ok;
   logic [rng_pkg::COUNT_BITS-1:0]         j_next;

   assign wr_pt.x   = req_data.pos_x;
   assign wr_pt.y   = req_data.pos_y;
   assign wr_pt.col = req_data.grid_col;
   assign wr_pt.row = req_data.grid_row;

   rng_ram #(
      .WIDTH (rng_pkg::POINT_BITS),
      .DEPTH (rng_pkg::MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_data.index),
      .wr_data (wr_pt),
      .rd_addr (ram_raddr),
      .rd_data (rd_word)
   );

   assign rd_pt = rng_pkg::point_type'(rd_word);

   assign n_sat = (pc_ff > rng_pkg::COUNT_BITS'(rng_pkg::MAX_POINTS))
                ? rng_pkg::COUNT_BITS'(rng_pkg::MAX_POINTS) : pc_ff;
   assign n_m1  = n_ff - rng_pkg::COUNT_BITS'(1);
   assign dmax  = (dik_ff > d3_ff) ? dik_ff : d3_ff;

   assign col_diff = (pi_ff.col >= rd_pt.col) ? pi_ff.col - rd_pt.col
                                              : rd_pt.col - pi_ff.col;
   assign row_diff = (pi_ff.row >= rd_pt.row) ? pi_ff.row - rd_pt.row
                                              : rd_pt.row - pi_ff.row;
   assign win_ok   = (col_diff < win_ff) && (row_diff < win_ff);
   assign k_ok     = (k_ff != i_ff) && (k_ff != j_ff);
   assign j_next   = {1'b0, j_ff} + rng_pkg::COUNT_BITS'(1);
   assign op_a     = iss_a_j ? pj_ff : pi_ff;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      pi_in        = pi_ff;
      pj_in        = pj_ff;
      jv_in        = jv_ff;
      beaten_in    = beaten_ff;
      pend_v_in    = pend_v_ff;
      pend_j_in    = pend_j_ff;
      dij_in       = dij_ff;
      dik_in       = dik_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_raddr    = k_ff;
      iss_v        = 1'b0;
      iss_side     = rng_pkg::SIDE_REF;
      iss_a_j      = 1'b0;

      // Results leaving the distance pipeline, always in issue order.
      if (v3_ff) begin
         case (s3_ff)
            rng_pkg::SIDE_REF: dij_in = d3_ff;
            rng_pkg::SIDE_I:   dik_in = d3_ff;
            rng_pkg::SIDE_J: begin
               if (dmax < dij_ff) begin
                  beaten_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      case (state_ff)
         rng_pkg::ST_IDLE: begin
            if (start) begin
               if (req_data.kind == rng_pkg::KIND_LOAD) begin
                  ram_we = 1'b1;
               end else begin
                  i_in = req_data.index;
                  n_in = n_sat;
                  if (({1'b0, req_data.index} < n_sat) &&
                      (req_data.index != '0)) begin
                     state_in = rng_pkg::ST_RD_I;
                  end else begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.row_point = req_data.index;
                     rsp_in.neighbor  = '0;
                     rsp_in.is_edge   = 1'b0;
                     rsp_in.last      = 1'b1;
                  end
               end
            end
         end
         rng_pkg::ST_RD_I: begin
            ram_raddr = i_ff;
            state_in  = rng_pkg::ST_LD_I;
         end
         rng_pkg::ST_LD_I: begin
            pi_in     = rd_pt;
            j_in      = '0;
            pend_v_in = 1'b0;
            state_in  = rng_pkg::ST_RD_J;
         end
         rng_pkg::ST_RD_J: begin
            ram_raddr = j_ff;
            state_in  = rng_pkg::ST_LD_J;
         end
         rng_pkg::ST_LD_J: begin
            pj_in     = rd_pt;
            beaten_in = 1'b0;
            jv_in     = 1'b0;
            k_in      = '0;
            if (win_ok) begin
               iss_v    = 1'b1;
               iss_side = rng_pkg::SIDE_REF;
               state_in = rng_pkg::ST_K_A;
            end else begin
               state_in = rng_pkg::ST_NEXT_J;
            end
         end
         rng_pkg::ST_K_A: begin
            // Read data still holds the previous third point for its j side.
            ram_raddr = k_ff;
            if (beaten_ff) begin
               state_in = rng_pkg::ST_DRAIN;
            end else begin
               iss_v    = jv_ff;
               iss_side = rng_pkg::SIDE_J;
               iss_a_j  = 1'b1;
               state_in = rng_pkg::ST_K_B;
            end
         end
         rng_pkg::ST_K_B: begin
            ram_raddr = k_ff;
            if (beaten_ff) begin
               state_in = rng_pkg::ST_DRAIN;
            end else begin
               iss_v    = k_ok;
               iss_side = rng_pkg::SIDE_I;
               jv_in    = k_ok;
               if (k_ff == n_m1[rng_pkg::INDEX_BITS-1:0]) begin
                  state_in = rng_pkg::ST_K_LAST;
               end else begin
                  k_in     = k_ff + rng_pkg::INDEX_BITS'(1);
                  state_in = rng_pkg::ST_K_A;
               end
            end
         end
         rng_pkg::ST_K_LAST: begin
            ram_raddr = k_ff;
            if (!beaten_ff) begin
               iss_v    = jv_ff;
               iss_side = rng_pkg::SIDE_J;
               iss_a_j  = 1'b1;
            end
            state_in = rng_pkg::ST_DRAIN;
         end
         rng_pkg::ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               // An edge is held back until the next one shows it is not last.
               if (!beaten_ff) begin
                  if (pend_v_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.row_point = i_ff;
                     rsp_in.neighbor  = pend_j_ff;
                     rsp_in.is_edge   = 1'b1;
                     rsp_in.last      = 1'b0;
                  end
                  pend_v_in = 1'b1;
                  pend_j_in = j_ff;
               end
               state_in = rng_pkg::ST_NEXT_J;
            end
         end
         rng_pkg::ST_NEXT_J: begin
            if (j_next < {1'b0, i_ff}) begin
               j_in     = j_next[rng_pkg::INDEX_BITS-1:0];
               state_in = rng_pkg::ST_RD_J;
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_in.row_point = i_ff;
               rsp_in.neighbor  = pend_v_ff ? pend_j_ff : '0;
               rsp_in.is_edge   = pend_v_ff;
               rsp_in.last      = 1'b1;
               state_in         = rng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rng_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rng_pkg::ST_IDLE;
         pc_ff        <= '0;
         win_ff       <= '1;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         beaten_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
         jv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= iss_v;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         beaten_ff    <= beaten_in;
         pend_v_ff    <= pend_v_in;
         jv_ff        <= jv_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rng_pkg::REG_POINT_COUNT: pc_ff  <= csr_data[rng_pkg::COUNT_BITS-1:0];
               rng_pkg::REG_CELL_WINDOW: win_ff <= csr_data[rng_pkg::WINDOW_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      n_ff      <= n_in;
      pi_ff     <= pi_in;
      pj_ff     <= pj_in;
      pend_j_ff <= pend_j_in;
      dij_ff    <= dij_in;
      dik_ff    <= dik_in;
      rsp_ff    <= rsp_in;
      s1_ff     <= iss_side;
      s2_ff     <= s1_ff;
      s3_ff     <= s2_ff;
      dx1_ff    <= rng_pkg::DIFF_BITS'(op_a.x) - rng_pkg::DIFF_BITS'(rd_pt.x);
      dy1_ff    <= rng_pkg::DIFF_BITS'(op_a.y) - rng_pkg::DIFF_BITS'(rd_pt.y);
      sqx2_ff   <= rng_pkg::DIST_BITS'(dx1_ff) * rng_pkg::DIST_BITS'(dx1_ff);
      sqy2_ff   <= rng_pkg::DIST_BITS'(dy1_ff) * rng_pkg::DIST_BITS'(dy1_ff);
      d3_ff     <= $unsigned(sqx2_ff) + $unsigned(sqy2_ff);
   end

   assign busy      = (state_ff != rng_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   // The window and count must not move under a running row.
   assign csr_ready = !busy;

`ifndef SYNTHESIS
   // A row without edges always closes with a single marked result.
   a_no_edge_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_edge |-> rsp_ff.last)
      else $error("no-edge result without last");

   // Edges only join a point to an earlier one.
   a_edge_earlier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_edge |-> rsp_ff.neighbor < rsp_ff.row_point)
      else $error("edge neighbor not below row point");

   // The distance pipeline carries work only during a row query.
   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> state_ff != rng_pkg::ST_IDLE)
      else $error("distance pipeline active while idle");

   // A pair is closed only once every distance in flight has been seen.
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == rng_pkg::ST_DRAIN && state_in == rng_pkg::ST_NEXT_J |->
      !v1_ff && !v2_ff && !v3_ff)
      else $error("pair closed with distances in flight");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the relative neighborhood graph row evaluator.
`timescale 1ns / 1ps
module tb_top;

   localparam int CLOCK_HALF     = 6;
   localparam int CLOCK_PERIOD   = 2 * CLOCK_HALF;
   localparam int RESET_CYCLES   = 10;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 200;
   localparam int TIMEOUT_CYCLES = 1000000;
   localparam int ITEM_TARGET    = 140;
   localparam int IDLE_ITEMS     = 115;

   // Phases of the random part that get a fixed shape.
   localparam int BIG_STACKED_PHASE = 1;
   localparam int EMPTY_PHASE       = 3;
   localparam int BIG_WIDE_PHASE    = 5;

   typedef enum logic [1:0] {
      ACT_ITEM,
      ACT_CSR,
      ACT_PAUSE
   } act_kind_type;

   typedef struct {
      act_kind_type                               act;
      rng_pkg::req_type                           req;
      logic [rng_pkg::CSR_INDEX_BITS-1:0]         reg_index;
      logic [rng_pkg::CSR_DATA_BITS-1:0]          reg_data;
      bit                                         may_idle;
   } action_type;

   // How the points of a phase are placed.
   typedef enum int {
      LAYOUT_WIDE,
      LAYOUT_CLUSTER,
      LAYOUT_LATTICE,
      LAYOUT_STACKED
   } layout_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   rng_pkg::req_type req_data = '0;
   logic rsp_valid;
   rng_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [rng_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [rng_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   relative_neighborhood_graph dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("tb_top: done, errors");
      $finish;
   end

   // Predicted copy of the point store and the two registers.
   rng_pkg::point_type point_mem [rng_pkg::MAX_POINTS];
   logic [rng_pkg::COUNT_BITS-1:0] count_reg = '0;
   logic [rng_pkg::WINDOW_BITS-1:0] window_reg = '1;

   rng_pkg::rsp_type expected_edges [$];
   action_type pending_actions [$];
   int error_count = 0;

   // Generator state.
   int item_total = 0;
   int idle_cutoff = IDLE_ITEMS;
   bit idle_on = 1'b1;
   layout_type layout = LAYOUT_WIDE;
   int center_x, center_y, cell_base, cell_spread;

   // Driver state.
   int idle_left = 0;
   int settle_left = 0;
   bit draining = 1'b0;
   bit rested = 1'b0;

   function automatic longint sq_dist(int a, int b);
      longint dx, dy;
      dx = longint'($signed(point_mem[a].x)) - longint'($signed(point_mem[b].x));
      dy = longint'($signed(point_mem[a].y)) - longint'($signed(point_mem[b].y));
      return dx * dx + dy * dy;
   endfunction

   // A pair is joined if its cells fall within the window and no third point is strictly closer to both ends.
   function automatic bit pair_joined(int i, int j, int n);
      longint span, to_i, to_j, worse;
      int dc, dr;
      dc = int'(point_mem[i].col) - int'(point_mem[j].col);
      dr = int'(point_mem[i].row) - int'(point_mem[j].row);
      if (dc < 0) dc = -dc;
      if (dr < 0) dr = -dr;
      if (dc >= int'(window_reg) || dr >= int'(window_reg)) return 1'b0;
      span = sq_dist(i, j);
      for (int k = 0; k < n; k++) begin
         if (k != i && k != j) begin
            to_i = sq_dist(i, k);
            to_j = sq_dist(j, k);
            worse = (to_i > to_j) ? to_i : to_j;
            if (worse < span) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void predict_row_edges(int i);
      int n;
      bit held;
      rng_pkg::rsp_type edge_rsp, prev;
      n = (count_reg > rng_pkg::MAX_POINTS) ? rng_pkg::MAX_POINTS : int'(count_reg);
      held = 1'b0;
      prev = '0;
      if (i < n) begin
         for (int j = 0; j < i; j++) begin
            if (pair_joined(i, j, n)) begin
               if (held) expected_edges.insert(expected_edges.size(), prev);
               edge_rsp.row_point = i[rng_pkg::INDEX_BITS-1:0];
               edge_rsp.neighbor = j[rng_pkg::INDEX_BITS-1:0];
               edge_rsp.is_edge = 1'b1;
               edge_rsp.last = 1'b0;
               prev = edge_rsp;
               held = 1'b1;
            end
         end
      end
      if (held) begin
         prev.last = 1'b1;
      end else begin
         prev.row_point = i[rng_pkg::INDEX_BITS-1:0];
         prev.neighbor = '0;
         prev.is_edge = 1'b0;
         prev.last = 1'b1;
      end
      expected_edges.insert(expected_edges.size(), prev);
   endfunction

   function automatic void absorb_request(rng_pkg::req_type r);
      if (r.kind == rng_pkg::KIND_LOAD) begin
         point_mem[r.index] = '{x: r.pos_x, y: r.pos_y, col: r.grid_col, row: r.grid_row};
      end else begin
         predict_row_edges(int'(r.index));
      end
   endfunction

   function automatic void absorb_register(logic [rng_pkg::CSR_INDEX_BITS-1:0] idx,
                                           logic [rng_pkg::CSR_DATA_BITS-1:0] data);
      if (idx == rng_pkg::REG_POINT_COUNT) begin
         count_reg = data[rng_pkg::COUNT_BITS-1:0];
      end else if (idx == rng_pkg::REG_CELL_WINDOW) begin
         window_reg = data[rng_pkg::WINDOW_BITS-1:0];
      end
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (got != want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void push_item(rng_pkg::req_type r);
      action_type a;
      a.act = ACT_ITEM;
      a.req = r;
      a.reg_index = '0;
      a.reg_data = '0;
      a.may_idle = idle_on && (item_total < idle_cutoff);
      pending_actions.insert(pending_actions.size(), a);
      item_total++;
   endfunction

   function automatic void push_load(int slot, int x, int y, int col, int row);
      rng_pkg::req_type r;
      r.kind = rng_pkg::KIND_LOAD;
      r.index = slot[rng_pkg::INDEX_BITS-1:0];
      r.pos_x = x[rng_pkg::COORD_BITS-1:0];
      r.pos_y = y[rng_pkg::COORD_BITS-1:0];
      r.grid_col = col[rng_pkg::CELL_BITS-1:0];
      r.grid_row = row[rng_pkg::CELL_BITS-1:0];
      push_item(r);
   endfunction

   // Unused fields of a query carry random bits.
   function automatic void push_query(int slot);
      logic [63:0] noise;
      rng_pkg::req_type r;
      noise = {$urandom, $urandom};
      r = noise[$bits(rng_pkg::req_type)-1:0];
      r.kind = rng_pkg::KIND_QUERY;
      r.index = slot[rng_pkg::INDEX_BITS-1:0];
      push_item(r);
   endfunction

   function automatic void push_register(logic [rng_pkg::CSR_INDEX_BITS-1:0] idx, int data);
      action_type a;
      a.act = ACT_CSR;
      a.req = '0;
      a.reg_index = idx;
      a.reg_data = data[rng_pkg::CSR_DATA_BITS-1:0];
      a.may_idle = idle_on && (item_total < idle_cutoff);
      pending_actions.insert(pending_actions.size(), a);
   endfunction

   function automatic void push_pause();
      action_type a;
      a.act = ACT_PAUSE;
      a.req = '0;
      a.reg_index = '0;
      a.reg_data = '0;
      a.may_idle = 1'b0;
      pending_actions.insert(pending_actions.size(), a);
   endfunction

   function automatic void push_random_load(int slot);
      int x, y;
      case (layout)
         LAYOUT_CLUSTER: begin
            x = center_x + $urandom_range(0, 96) - 48;
            y = center_y + $urandom_range(0, 96) - 48;
         end
         LAYOUT_LATTICE: begin
            x = 16 * $urandom_range(0, 2);
            y = 16 * $urandom_range(0, 2);
         end
         LAYOUT_STACKED: begin
            x = center_x + (($urandom_range(0, 9) == 0) ? 16 : 0);
            y = center_y;
         end
         default: begin
            x = $urandom;
            y = $urandom;
         end
      endcase
      push_load(slot, x, y, cell_base + $urandom_range(0, cell_spread),
                cell_base + $urandom_range(0, cell_spread));
   endfunction

   // Driver: retires accepted transactions, then issues the next pending action.
   always @(posedge clock) begin : driver
      bit nxt_start, nxt_csr;
      action_type a;
      nxt_start = start;
      nxt_csr = csr_valid;
      if (reset) begin
         nxt_start = 1'b0;
         nxt_csr = 1'b0;
      end else begin
         if (start && !busy) begin
            absorb_request(req_data);
            nxt_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            absorb_register(csr_index, csr_data);
            nxt_csr = 1'b0;
         end
         if (!nxt_start && !nxt_csr) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (draining) begin
               if (expected_edges.size() == 0) begin
                  if (settle_left > 0) settle_left--;
                  else draining = 1'b0;
               end
            end else if (pending_actions.size() != 0) begin
               a = pending_actions[0];
               if (a.may_idle && !rested && $urandom_range(0, 4) == 0) begin
                  idle_left = $urandom_range(0, 18);
                  rested = 1'b1;
               end else begin
                  rested = 1'b0;
                  void'(pending_actions.pop_front());
                  case (a.act)
                     ACT_ITEM: begin
                        nxt_start = 1'b1;
                        req_data <= a.req;
                     end
                     ACT_CSR: begin
                        nxt_csr = 1'b1;
                        csr_index <= a.reg_index;
                        csr_data <= a.reg_data;
                     end
                     default: begin
                        draining = 1'b1;
                        settle_left = SETTLE_CYCLES;
                     end
                  endcase
               end
            end
         end
      end
      start <= nxt_start;
      csr_valid <= nxt_csr;
   end

   always @(posedge clock) begin : monitor
      rng_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_edges.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual row %0d neighbor %0d %s",
                     $time, rsp_data.row_point, rsp_data.neighbor,
                     $sformatf("edge %0b last %0b", rsp_data.is_edge, rsp_data.last));
            error_count++;
         end else begin
            want = expected_edges.pop_front();
            compare_field("row_point", int'(want.row_point), int'(rsp_data.row_point));
            compare_field("neighbor", int'(want.neighbor), int'(rsp_data.neighbor));
            compare_field("is_edge", int'(want.is_edge), int'(rsp_data.is_edge));
            compare_field("last", int'(want.last), int'(rsp_data.last));
         end
      end
   end

   initial begin : stimulus
      int phase, n, count_data, win, queries, pick;

      // Nothing loaded and a zero point count: every row lies past the count.
      push_query(0);
      push_query(rng_pkg::MAX_POINTS - 1);
      push_load(0, -32768, -32768, 0, 0);
      push_load(1, 32767, 32767, 255, 255);
      push_load(2, 0, 0, 10, 10);
      push_load(3, 0, 0, 10, 10);
      push_load(4, 16, -16, 11, 9);
      push_load(5, 100, 50, 12, 12);
      push_pause();
      push_register(rng_pkg::REG_POINT_COUNT, 6);
      // Row 0 has no earlier point, and row 6 is at the count.
      for (int q = 0; q <= 6; q++) push_query(q);
      // A zero window rejects every pair.
      push_pause();
      push_register(rng_pkg::REG_CELL_WINDOW, 0);
      push_query(5);
      push_query(3);
      // A window of one passes only points in the same cell.
      push_pause();
      push_register(rng_pkg::REG_CELL_WINDOW, 1);
      push_query(3);
      push_query(5);
      push_pause();
      push_register(rng_pkg::REG_CELL_WINDOW, 2);
      push_query(4);
      push_query(5);

      phase = 0;
      while (item_total < ITEM_TARGET || phase <= BIG_WIDE_PHASE) begin
         idle_on = ($urandom_range(0, 3) != 0);
         push_pause();
         layout = layout_type'($urandom_range(0, 3));
         center_x = $urandom;
         center_y = $urandom;
         cell_base = $urandom_range(0, 255);
         cell_spread = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) begin
            cell_base = 0;
            cell_spread = 255;
         end
         case ($urandom_range(0, 5))
            0: win = 0;
            1: win = 1;
            2: win = $urandom_range(2, 8);
            3: win = 255;
            default: win = $urandom_range(0, 255);
         endcase
         count_data = $urandom_range(1, 8);
         if (phase == BIG_STACKED_PHASE) begin
            // All points nearly on one spot, so long rows produce many edges.
            layout = LAYOUT_STACKED;
            cell_spread = 3;
            win = 255;
            count_data = 8'hFF;
         end else if (phase == EMPTY_PHASE) begin
            count_data = 0;
         end else if (phase == BIG_WIDE_PHASE) begin
            layout = LAYOUT_WIDE;
            win = $urandom_range(128, 255);
            count_data = rng_pkg::MAX_POINTS;
         end
         // The count register keeps seven bits and saturates at the store depth.
         n = count_data % 128;
         if (n > rng_pkg::MAX_POINTS) n = rng_pkg::MAX_POINTS;
         if ($urandom_range(0, 1) == 1) begin
            push_register(rng_pkg::REG_POINT_COUNT, count_data);
            push_register(rng_pkg::REG_CELL_WINDOW, win);
         end else begin
            push_register(rng_pkg::REG_CELL_WINDOW, win);
            push_register(rng_pkg::REG_POINT_COUNT, count_data);
         end
         if (phase == BIG_WIDE_PHASE || phase == EMPTY_PHASE) begin
            repeat (4) push_random_load($urandom_range(0, rng_pkg::MAX_POINTS - 1));
         end else begin
            for (int s = 0; s < n; s++) push_random_load(s);
         end
         if (n == rng_pkg::MAX_POINTS) begin
            push_query(rng_pkg::MAX_POINTS - 1);
            push_query($urandom_range(0, rng_pkg::MAX_POINTS - 1));
            push_query($urandom_range(0, rng_pkg::MAX_POINTS - 1));
         end else begin
            queries = $urandom_range(2, 5);
            repeat (queries) begin
               pick = $urandom_range(0, 9);
               if (pick < 2) begin
                  push_random_load($urandom_range(0, rng_pkg::MAX_POINTS - 1));
               end else if (pick == 2) begin
                  push_pause();
               end
               push_query($urandom_range(0, (n == 0) ? rng_pkg::MAX_POINTS - 1 : n + 2));
            end
         end
         phase++;
      end

      while (pending_actions.size() != 0 || start || csr_valid || draining ||
             idle_left != 0 || expected_edges.size() != 0)
         @(negedge clock);
      repeat (END_CYCLES) @(negedge clock);
      if (error_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

endmodule
